// ===== rtl/core/dvrt_pkg.sv =====
// Shared types and constants for the distance-vector route table engine.
`default_nettype none

package dvrt_pkg;

    // Default table sizes.
    localparam int ROUTE_ENTRIES_DEF    = 64;
    localparam int NEIGHBOR_ENTRIES_DEF = 8;

    // Field widths.
    localparam int ID_W   = 16;
    localparam int COST_W = 32;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD_NB = 2'd1,
        CMD_ADVERT = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_code_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NO_CHANGE = 2'd0,
        ST_CHANGED   = 2'd1,
        ST_DROPPED   = 2'd2,
        ST_NO_ROUTE  = 2'd3
    } stat_code_t;

    // One command transfer.
    typedef struct packed {
        cmd_code_t           command;
        logic [ID_W-1:0]     source_id;
        logic [ID_W-1:0]     dest_id;
        logic [COST_W-1:0]   cost_in;
    } in_t;

    // One result transfer.
    typedef struct packed {
        stat_code_t          status;
        logic                route_found;
        logic [ID_W-1:0]     next_hop;
        logic [COST_W-1:0]   route_cost;
    } out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic nscan;
        logic rscan;
        logic update;
    } ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic nscan_done;
        logic rscan_done;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dvrt_datapath.sv =====
// Datapath: neighbor and route table memories, search pointers and update logic.
`default_nettype none

module dvrt_datapath #(
    parameter int ROUTE_ENTRIES    = dvrt_pkg::ROUTE_ENTRIES_DEF,
    parameter int NEIGHBOR_ENTRIES = dvrt_pkg::NEIGHBOR_ENTRIES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dvrt_pkg::in_t             cmd,
    input  wire logic                      cfg_we,
    input  wire logic [dvrt_pkg::ID_W-1:0] cfg_data,
    input  wire dvrt_pkg::ctl_t            ctl,
    output dvrt_pkg::sts_t                 sts,
    output dvrt_pkg::out_t                 result
);
    import dvrt_pkg::*;

    localparam int RIW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
    localparam int NIW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
    localparam int NCW = $clog2(NEIGHBOR_ENTRIES + 1);
    localparam logic [RCW-1:0] RT_FULL = RCW'(ROUTE_ENTRIES);
    localparam logic [NCW-1:0] NB_FULL = NCW'(NEIGHBOR_ENTRIES);

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [COST_W-1:0] metric;
    } nb_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]   dest;
        logic [ID_W-1:0]   hop;
        logic [COST_W-1:0] metric;
    } rt_entry_t;

    // Table memories.
    nb_entry_t nb_mem [NEIGHBOR_ENTRIES];
    rt_entry_t rt_mem [ROUTE_ENTRIES];
    nb_entry_t nb_rdata_reg;
    rt_entry_t rt_rdata_reg;

    // Control registers.
    logic [ID_W-1:0] own_id_reg;
    logic [NCW-1:0]  nb_count_reg, nb_count_next;
    logic [RCW-1:0]  rt_count_reg, rt_count_next;
    logic [NCW-1:0]  nb_idx_reg, nb_idx_next;
    logic [RCW-1:0]  rt_idx_reg, rt_idx_next;
    logic            nb_pend_reg, nb_pend_next;
    logic            rt_pend_reg, rt_pend_next;

    // Payload registers.
    in_t               cmd_reg;
    logic [NIW-1:0]    nb_pidx_reg;
    logic [RIW-1:0]    rt_pidx_reg;
    logic              nb_found_reg;
    logic [NIW-1:0]    nb_at_reg;
    logic [COST_W-1:0] link_reg;
    logic              rt_found_reg;
    logic [RIW-1:0]    rt_at_reg;
    logic [ID_W-1:0]   rt_hop_reg;
    logic [COST_W-1:0] rt_metric_reg;
    out_t              result_reg, result_next;

    // Search compare logic.
    logic [ID_W-1:0] nb_key;
    logic            nb_issue, nb_hit;
    logic            rt_issue, rt_hit;

    // Update decision.
    logic              nb_we;
    logic [NIW-1:0]    nb_waddr;
    nb_entry_t         nb_wdata;
    logic              rt_we;
    logic [RIW-1:0]    rt_waddr;
    rt_entry_t         rt_wdata;
    logic [COST_W:0]   sum_w;
    logic [COST_W-1:0] total;
    logic              nb_room, rt_room;

    // The neighbor search looks for the source on an advertisement, else the destination.
    assign nb_key   = (cmd_reg.command == CMD_ADVERT) ? cmd_reg.source_id : cmd_reg.dest_id;
    assign nb_issue = nb_idx_reg < nb_count_reg;
    assign nb_hit   = nb_pend_reg && (nb_rdata_reg.ident == nb_key);
    assign rt_issue = rt_idx_reg < rt_count_reg;
    assign rt_hit   = rt_pend_reg && (rt_rdata_reg.dest == cmd_reg.dest_id);

    // A search ends on the first hit or once the last read entry has been compared.
    assign sts.nscan_done = nb_hit || (!nb_pend_reg && !nb_issue);
    assign sts.rscan_done = rt_hit || (!rt_pend_reg && !rt_issue);

    // Search pointers: one read issued per cycle, compared in the next.
    always_comb
    begin
        nb_idx_next  = nb_idx_reg;
        nb_pend_next = nb_pend_reg;
        rt_idx_next  = rt_idx_reg;
        rt_pend_next = rt_pend_reg;
        if (ctl.load)
        begin
            nb_idx_next  = '0;
            nb_pend_next = 1'b0;
            rt_idx_next  = '0;
            rt_pend_next = 1'b0;
        end
        else
        begin
            if (ctl.nscan)
            begin
                nb_pend_next = nb_issue;
                if (nb_issue)
                begin
                    nb_idx_next = nb_idx_reg + NCW'(1);
                end
            end
            if (ctl.rscan)
            begin
                rt_pend_next = rt_issue;
                if (rt_issue)
                begin
                    rt_idx_next = rt_idx_reg + RCW'(1);
                end
            end
        end
    end

    // Saturating path cost and table room.
    assign sum_w   = {1'b0, cmd_reg.cost_in} + {1'b0, link_reg};
    assign total   = sum_w[COST_W] ? {COST_W{1'b1}} : sum_w[COST_W-1:0];
    assign nb_room = nb_count_reg < NB_FULL;
    assign rt_room = rt_count_reg < RT_FULL;

    // Table update and result, applied in the update cycle.
    always_comb
    begin
        nb_we         = 1'b0;
        nb_waddr      = nb_found_reg ? nb_at_reg : nb_count_reg[NIW-1:0];
        nb_wdata      = '{ident: cmd_reg.dest_id, metric: cmd_reg.cost_in};
        rt_we         = 1'b0;
        rt_waddr      = rt_found_reg ? rt_at_reg : rt_count_reg[RIW-1:0];
        rt_wdata      = '{dest: cmd_reg.dest_id, hop: cmd_reg.dest_id, metric: cmd_reg.cost_in};
        nb_count_next = nb_count_reg;
        rt_count_next = rt_count_reg;
        // By default the result shows the route as found by the search.
        result_next.status      = ST_NO_CHANGE;
        result_next.route_found = rt_found_reg;
        result_next.next_hop    = rt_found_reg ? rt_hop_reg : '0;
        result_next.route_cost  = rt_found_reg ? rt_metric_reg : '0;
        unique case (cmd_reg.command)
            CMD_CLEAR:
            begin
                nb_count_next           = '0;
                rt_count_next           = '0;
                result_next.status      = ST_CHANGED;
                result_next.route_found = 1'b0;
                result_next.next_hop    = '0;
                result_next.route_cost  = '0;
            end
            CMD_ADD_NB:
            begin
                if (!nb_found_reg && !nb_room)
                begin
                    result_next.status = ST_DROPPED;
                end
                else
                begin
                    nb_we              = 1'b1;
                    result_next.status = ST_CHANGED;
                    if (!nb_found_reg)
                    begin
                        nb_count_next = nb_count_reg + NCW'(1);
                    end
                    // Direct route: overwrite if found, else add unless full or own id.
                    if (rt_found_reg || ((cmd_reg.dest_id != own_id_reg) && rt_room))
                    begin
                        rt_we                   = 1'b1;
                        result_next.route_found = 1'b1;
                        result_next.next_hop    = cmd_reg.dest_id;
                        result_next.route_cost  = cmd_reg.cost_in;
                        if (!rt_found_reg)
                        begin
                            rt_count_next = rt_count_reg + RCW'(1);
                        end
                    end
                    else if (cmd_reg.dest_id != own_id_reg)
                    begin
                        result_next.status = ST_DROPPED;
                    end
                end
            end
            CMD_ADVERT:
            begin
                rt_wdata.hop    = cmd_reg.source_id;
                rt_wdata.metric = total;
                if ((rt_found_reg && (total < rt_metric_reg))
                    || (!rt_found_reg && (cmd_reg.dest_id != own_id_reg) && rt_room))
                begin
                    rt_we                   = 1'b1;
                    result_next.status      = ST_CHANGED;
                    result_next.route_found = 1'b1;
                    result_next.next_hop    = cmd_reg.source_id;
                    result_next.route_cost  = total;
                    if (!rt_found_reg)
                    begin
                        rt_count_next = rt_count_reg + RCW'(1);
                    end
                end
                else if (!rt_found_reg && (cmd_reg.dest_id != own_id_reg))
                begin
                    result_next.status = ST_DROPPED;
                end
            end
            CMD_LOOKUP:
            begin
                result_next.status = rt_found_reg ? ST_NO_CHANGE : ST_NO_ROUTE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= '0;
            nb_count_reg <= '0;
            rt_count_reg <= '0;
            nb_idx_reg   <= '0;
            rt_idx_reg   <= '0;
            nb_pend_reg  <= 1'b0;
            rt_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_id_reg <= cfg_data;
            end
            if (ctl.update)
            begin
                nb_count_reg <= nb_count_next;
                rt_count_reg <= rt_count_next;
            end
            nb_idx_reg  <= nb_idx_next;
            rt_idx_reg  <= rt_idx_next;
            nb_pend_reg <= nb_pend_next;
            rt_pend_reg <= rt_pend_next;
        end
    end

    // Payload registers: command, search index pipeline, search results, result.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
        end
        nb_pidx_reg <= nb_idx_reg[NIW-1:0];
        rt_pidx_reg <= rt_idx_reg[RIW-1:0];
        if (ctl.nscan && sts.nscan_done)
        begin
            nb_found_reg <= nb_hit;
            nb_at_reg    <= nb_pidx_reg;
            link_reg     <= nb_hit ? nb_rdata_reg.metric : '0;
        end
        if (ctl.rscan && sts.rscan_done)
        begin
            rt_found_reg  <= rt_hit;
            rt_at_reg     <= rt_pidx_reg;
            rt_hop_reg    <= rt_rdata_reg.hop;
            rt_metric_reg <= rt_rdata_reg.metric;
        end
        if (ctl.update)
        begin
            result_reg <= result_next;
        end
    end

    // Neighbor table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.update && nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        nb_rdata_reg <= nb_mem[nb_idx_reg[NIW-1:0]];
    end

    // Route table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.update && rt_we)
        begin
            rt_mem[rt_waddr] <= rt_wdata;
        end
        rt_rdata_reg <= rt_mem[rt_idx_reg[RIW-1:0]];
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dvrt_ctrl.sv =====
// Controller: sequences the neighbor search, route search and table update.
`default_nettype none

module dvrt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire dvrt_pkg::cmd_code_t command,
    input  wire dvrt_pkg::sts_t      sts,
    output dvrt_pkg::ctl_t           ctl,
    output logic                     busy,
    output logic                     done
);
    import dvrt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_NSCAN  = 4'b0010,
        S_RSCAN  = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    unique case (command)
                        CMD_CLEAR:  state_next = S_UPDATE;
                        CMD_LOOKUP: state_next = S_RSCAN;
                        CMD_ADD_NB,
                        CMD_ADVERT: state_next = S_NSCAN;
                    endcase
                end
            end
            S_NSCAN:
            begin
                ctl.nscan = 1'b1;
                if (sts.nscan_done)
                begin
                    state_next = S_RSCAN;
                end
            end
            S_RSCAN:
            begin
                ctl.rscan = 1'b1;
                if (sts.rscan_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                ctl.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result strobe follows the update cycle.
    assign done_next = (state_reg == S_UPDATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/distance_vector_route_table_top.sv =====
// Top level of the distance-vector route table engine.
//
// Channel   Handshake                  Payload
// command   start in, busy out         cmd (dvrt_pkg::in_t)
// result    done out (one-cycle)       result (dvrt_pkg::out_t)
// config    cfg_valid in, cfg_ready    cfg_data (own node id)
//
// A command transfer takes place when start is high and busy is low. Each search
// compares one entry per cycle through its table memory's read port and stops at
// the first hit. Lookup skips the neighbor search and clear skips both searches.
// Reset empties both tables and clears the node id. Results cannot be stalled.
`default_nettype none

module distance_vector_route_table_top #(
    parameter int ROUTE_ENTRIES    = dvrt_pkg::ROUTE_ENTRIES_DEF,
    parameter int NEIGHBOR_ENTRIES = dvrt_pkg::NEIGHBOR_ENTRIES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire dvrt_pkg::in_t             cmd,
    output logic                           done,
    output dvrt_pkg::out_t                 result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [dvrt_pkg::ID_W-1:0] cfg_data
);
    import dvrt_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // The node id register takes a transfer at any time.
    assign cfg_ready = 1'b1;

    dvrt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (cmd.command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    dvrt_datapath #(
        .ROUTE_ENTRIES    (ROUTE_ENTRIES),
        .NEIGHBOR_ENTRIES (NEIGHBOR_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .ctl      (ctl),
        .sts      (sts),
        .result   (result)
    );

`ifndef NO_ASSERTIONS
    // An accepted command keeps the engine busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Each command yields a single strobe, so strobes never come back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A missing route reports zero next hop and zero cost.
    a_no_route_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.route_found) |-> (result.next_hop == '0 && result.route_cost == '0))
        else $error("missing route with nonzero hop or cost");

    // Status no-route only appears without a route.
    a_status_route: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_NO_ROUTE) |-> !result.route_found)
        else $error("no-route status with a route found");
`endif

endmodule

`default_nettype wire

// ===== sim/distance_vector_route_table_top_tb.sv =====
// Self-checking testbench for the distance-vector route table engine.
`timescale 1ns / 1ps

module distance_vector_route_table_top_tb;
    import dvrt_pkg::*;

    localparam int RT_DEPTH       = ROUTE_ENTRIES_DEF;
    localparam int NB_DEPTH       = NEIGHBOR_ENTRIES_DEF;
    localparam int ID_POOL        = 80;
    localparam int FLOOD_ROUTES   = RT_DEPTH + 6;
    localparam int PHASE_ITEMS    = 500;
    localparam int SETTLE_CYCLES  = 100;
    localparam int STALL_LIMIT    = 5000;

    // One row of the directed stimulus table.
    typedef struct {
        in_t  c;
        bit   typed;
        out_t want;
    } step_row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    in_t             cmd = '0;
    logic            done;
    out_t            result;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [ID_W-1:0] cfg_data = '0;

    // Shadow copy of the route and neighbor tables.
    logic [ID_W-1:0]   rt_dest [RT_DEPTH];
    logic [ID_W-1:0]   rt_next [RT_DEPTH];
    logic [COST_W-1:0] rt_cost [RT_DEPTH];
    int                rt_count = 0;
    logic [ID_W-1:0]   nb_id   [NB_DEPTH];
    logic [COST_W-1:0] nb_cost [NB_DEPTH];
    int                nb_count = 0;
    logic [ID_W-1:0]   own_id = '0;

    out_t            pending_routes [$];
    step_row_t       directed [$];
    logic [ID_W-1:0] id_pool [ID_POOL];
    int              sender_idle_pct = 0;
    int              fault_count = 0;
    int              commands_sent = 0;
    int              routes_checked = 0;
    int              own_id_writes = 0;
    int              status_tally [4];

    distance_vector_route_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        fault_count++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    function automatic int find_route(input logic [ID_W-1:0] dest);
        for (int i = 0; i < rt_count; i++)
        begin
            if (rt_dest[i] == dest)
                return i;
        end
        return -1;
    endfunction

    function automatic int find_neighbor(input logic [ID_W-1:0] id);
        for (int i = 0; i < nb_count; i++)
        begin
            if (nb_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Appends a route; returns 0 when the table is already full.
    function automatic bit add_route(input logic [ID_W-1:0] dest, input logic [ID_W-1:0] hop,
                                     input logic [COST_W-1:0] metric);
        if (rt_count >= RT_DEPTH)
            return 1'b0;
        rt_dest[rt_count] = dest;
        rt_next[rt_count] = hop;
        rt_cost[rt_count] = metric;
        rt_count++;
        return 1'b1;
    endfunction

    // Applies one command to the shadow tables and returns the route report it gives.
    function automatic out_t predict_route(input in_t c);
        int                nb;
        int                rt;
        logic [COST_W:0]   wide_sum;
        logic [COST_W-1:0] total;
        logic [COST_W-1:0] link;
        stat_code_t        st;
        out_t              r;
        st = ST_NO_CHANGE;
        case (c.command)
            CMD_CLEAR:
            begin
                rt_count = 0;
                nb_count = 0;
                st = ST_CHANGED;
            end
            CMD_ADD_NB:
            begin
                nb = find_neighbor(c.dest_id);
                if (nb < 0 && nb_count >= NB_DEPTH)
                    st = ST_DROPPED;
                else
                begin
                    if (nb >= 0)
                        nb_cost[nb] = c.cost_in;
                    else
                    begin
                        nb_id[nb_count] = c.dest_id;
                        nb_cost[nb_count] = c.cost_in;
                        nb_count++;
                    end
                    st = ST_CHANGED;
                    // The direct route always replaces whatever route exists.
                    rt = find_route(c.dest_id);
                    if (rt >= 0)
                    begin
                        rt_next[rt] = c.dest_id;
                        rt_cost[rt] = c.cost_in;
                    end
                    else if (c.dest_id != own_id)
                    begin
                        if (!add_route(c.dest_id, c.dest_id, c.cost_in))
                            st = ST_DROPPED;
                    end
                end
            end
            CMD_ADVERT:
            begin
                // An unknown source contributes a zero link cost; the sum saturates.
                nb = find_neighbor(c.source_id);
                link = (nb >= 0) ? nb_cost[nb] : '0;
                wide_sum = {1'b0, c.cost_in} + {1'b0, link};
                total = wide_sum[COST_W] ? '1 : wide_sum[COST_W-1:0];
                rt = find_route(c.dest_id);
                if (rt >= 0)
                begin
                    if (total < rt_cost[rt])
                    begin
                        rt_next[rt] = c.source_id;
                        rt_cost[rt] = total;
                        st = ST_CHANGED;
                    end
                end
                else if (c.dest_id != own_id)
                begin
                    st = add_route(c.dest_id, c.source_id, total) ? ST_CHANGED : ST_DROPPED;
                end
            end
            default:
            begin
            end
        endcase
        rt = find_route(c.dest_id);
        if (c.command == CMD_LOOKUP)
            st = (rt >= 0) ? ST_NO_CHANGE : ST_NO_ROUTE;
        r.status      = st;
        r.route_found = (rt >= 0);
        r.next_hop    = (rt >= 0) ? rt_next[rt] : '0;
        r.route_cost  = (rt >= 0) ? rt_cost[rt] : '0;
        return r;
    endfunction

    function automatic step_row_t mk_row(input cmd_code_t op, input logic [ID_W-1:0] src,
                                         input logic [ID_W-1:0] dst,
                                         input logic [COST_W-1:0] cost, input bit typed,
                                         input stat_code_t st, input logic found,
                                         input logic [ID_W-1:0] hop,
                                         input logic [COST_W-1:0] metric);
        step_row_t row;
        row.c.command          = op;
        row.c.source_id        = src;
        row.c.dest_id          = dst;
        row.c.cost_in          = cost;
        row.typed              = typed;
        row.want.status        = st;
        row.want.route_found   = found;
        row.want.next_hop      = hop;
        row.want.route_cost    = metric;
        return row;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(input step_row_t row);
        directed = {directed, row};
    endtask

    // Ids mostly come from a small pool so that routes and neighbors are hit again.
    function automatic logic [ID_W-1:0] pick_id();
        int p;
        p = $urandom_range(99);
        if (p < 80)
            return id_pool[$urandom_range(ID_POOL - 1)];
        else if (p < 86)
            return own_id;
        else if (p < 88)
            return '0;
        else if (p < 90)
            return '1;
        return ID_W'($urandom);
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        int p;
        p = $urandom_range(99);
        if (p < 40)
            return $urandom_range(255);
        else if (p < 60)
            return '1 - $urandom_range(255);
        return $urandom;
    endfunction

    function automatic in_t random_command();
        in_t c;
        int  k;
        k = $urandom_range(999);
        c.source_id = ID_W'($urandom);
        c.dest_id   = pick_id();
        c.cost_in   = $urandom;
        if (k < 8)
            c.command = CMD_CLEAR;
        else if (k < 120)
        begin
            c.command = CMD_ADD_NB;
            c.cost_in = pick_cost();
        end
        else if (k < 700)
        begin
            // Mostly well-formed advertisements from a known neighbor.
            c.command = CMD_ADVERT;
            c.cost_in = pick_cost();
            if (nb_count > 0 && $urandom_range(99) < 75)
                c.source_id = nb_id[$urandom_range(nb_count - 1)];
            else
                c.source_id = pick_id();
        end
        else
            c.command = CMD_LOOKUP;
        return c;
    endfunction

    // Offers one command until it is taken, idling at random, then records its expected result.
    task automatic issue_command(input in_t c, input bit typed, input out_t typed_res);
        bit   taken;
        out_t want;
        taken = 1'b0;
        while (!taken)
        begin
            start <= ($urandom_range(99) >= sender_idle_pct);
            cmd   <= c;
            @(posedge clk);
            taken = start && !busy;
        end
        want = predict_route(c);
        if (typed)
            want = typed_res;
        pending_routes = {pending_routes, want};
        commands_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_own_id(input logic [ID_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        own_id = value;
        own_id_writes++;
    endtask

    // Clears the tables, fills the route table past capacity, then adds neighbors whose routes cannot fit.
    task automatic flood_routes();
        in_t c;
        c = '0;
        issue_command(c, 1'b0, '0);
        for (int i = 0; i < FLOOD_ROUTES; i++)
        begin
            c.command   = CMD_ADVERT;
            c.source_id = pick_id();
            c.dest_id   = id_pool[i];
            c.cost_in   = pick_cost();
            issue_command(c, 1'b0, '0);
        end
        for (int i = 0; i < 3; i++)
        begin
            c.command   = CMD_ADD_NB;
            c.source_id = ID_W'($urandom);
            c.dest_id   = ID_W'($urandom);
            c.cost_in   = pick_cost();
            issue_command(c, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int idle_pct, input logic [ID_W-1:0] node_id);
        drain_results();
        write_own_id(node_id);
        for (int i = 0; i < ID_POOL; i++)
            id_pool[i] = ID_W'($urandom);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 3)
                flood_routes();
            issue_command(random_command(), 1'b0, '0);
        end
    endtask

    // Result checker: every strobe must match the oldest outstanding expectation.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (pending_routes.size() == 0)
                flag_error("result strobe with no command outstanding");
            else
            begin
                want = pending_routes.pop_front();
                routes_checked++;
                status_tally[want.status]++;
                if (result.status !== want.status)
                    flag_error($sformatf("route status exp %0d got %0d",
                                         want.status, result.status));
                if (result.route_found !== want.route_found)
                    flag_error($sformatf("route_found exp %0d got %0d",
                                         want.route_found, result.route_found));
                if (result.next_hop !== want.next_hop)
                    flag_error($sformatf("next_hop exp %h got %h",
                                         want.next_hop, result.next_hop));
                if (result.route_cost !== want.route_cost)
                    flag_error($sformatf("route_cost exp %h got %h",
                                         want.route_cost, result.route_cost));
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t ERROR no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Main sequence.
    initial
    begin
        foreach (status_tally[i])
            status_tally[i] = 0;

        // Directed table, own id zero. Typed rows can be read off directly.
        add_row(mk_row(CMD_LOOKUP, 16'h0000, 16'h0000, 32'h0, 1'b1,
                       ST_NO_ROUTE, 1'b0, 16'h0, 32'h0));
        add_row(mk_row(CMD_LOOKUP, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
                       ST_NO_ROUTE, 1'b0, 16'h0, 32'h0));
        // Neighbor equal to own id: stored, but no route.
        add_row(mk_row(CMD_ADD_NB, 16'h0000, 16'h0000, 32'd5, 1'b1,
                       ST_CHANGED, 1'b0, 16'h0, 32'h0));
        add_row(mk_row(CMD_ADD_NB, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
                       ST_CHANGED, 1'b1, 16'hFFFF, 32'hFFFFFFFF));
        add_row(mk_row(CMD_ADD_NB, 16'h0000, 16'h0001, 32'd0, 1'b1,
                       ST_CHANGED, 1'b1, 16'h0001, 32'd0));
        // Saturating sum through the most expensive neighbor.
        add_row(mk_row(CMD_ADVERT, 16'hFFFF, 16'h0100, 32'd1, 1'b1,
                       ST_CHANGED, 1'b1, 16'hFFFF, 32'hFFFFFFFF));
        add_row(mk_row(CMD_ADVERT, 16'h0001, 16'h0100, 32'd7, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        // Same cost again is not cheaper.
        add_row(mk_row(CMD_ADVERT, 16'h0001, 16'h0100, 32'd7, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        // Source that is not a neighbor.
        add_row(mk_row(CMD_ADVERT, 16'h1234, 16'h0200, 32'd3, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        // Advertisement for this node itself.
        add_row(mk_row(CMD_ADVERT, 16'h0000, 16'h0000, 32'd9, 1'b1,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        // Known neighbor gets a new link cost.
        add_row(mk_row(CMD_ADD_NB, 16'h0000, 16'h0001, 32'd9, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        add_row(mk_row(CMD_ADVERT, 16'h0001, 16'h0300, 32'd0, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        add_row(mk_row(CMD_LOOKUP, 16'h0000, 16'h0300, 32'h0, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        // Direct route overrides a cheaper learned route.
        add_row(mk_row(CMD_ADD_NB, 16'h0000, 16'h0100, 32'hFFFF0000, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        for (int i = 2; i <= 5; i++)
            add_row(mk_row(CMD_ADD_NB, 16'h0000, i[ID_W-1:0], i, 1'b0,
                           ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        // Neighbor table is full now.
        add_row(mk_row(CMD_ADD_NB, 16'h0000, 16'h0006, 32'd6, 1'b1,
                       ST_DROPPED, 1'b0, 16'h0, 32'h0));
        add_row(mk_row(CMD_ADVERT, 16'h0006, 16'h0400, 32'd8, 1'b0,
                       ST_NO_CHANGE, 1'b0, 16'h0, 32'h0));
        add_row(mk_row(CMD_CLEAR, 16'h0000, 16'h0001, 32'h0, 1'b1,
                       ST_CHANGED, 1'b0, 16'h0, 32'h0));
        add_row(mk_row(CMD_LOOKUP, 16'h0000, 16'h0001, 32'h0, 1'b1,
                       ST_NO_ROUTE, 1'b0, 16'h0, 32'h0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_own_id('0);
        sender_idle_pct = 9;
        foreach (directed[i])
            issue_command(directed[i].c, directed[i].typed, directed[i].want);

        // Random phases: light sender idling, heavy idling, then none.
        run_phase(9, 16'hFFFF);
        run_phase(63, 16'($urandom));
        run_phase(0, 16'h0001);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d commands with %0d results checked across %0d node id settings.",
                 commands_sent, routes_checked, own_id_writes);
        $display("Outcome tally: no change %0d, changed %0d, dropped %0d, no route %0d.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
